// ===== design/lrumtf_pkg.sv =====
package lrumtf_pkg;

    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_item_in;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] found_value;
        logic [DATA_W-1:0] hit_total;
        logic [DATA_W-1:0] miss_total;
    } t_item_out;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_kv;

    // match carry passed front to back along the cells
    typedef struct packed {
        logic              matched;
        logic [DATA_W-1:0] value;
    } t_chain;

endpackage

// ===== design/lrumtf_cell.sv =====
module lrumtf_cell
    import lrumtf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_valid,
    input  logic   [DATA_W-1:0] i_key,
    input  t_chain i_chain,
    output t_chain o_chain,
    input  logic   i_load,
    input  t_kv    i_din,
    output t_kv    o_kv
);

    t_kv  r_kv;
    logic w_match;

    assign w_match = i_valid && (r_kv.key == i_key);

    always_comb begin
        o_chain.matched = i_chain.matched | w_match;
        o_chain.value   = (w_match && !i_chain.matched) ? r_kv.value : i_chain.value;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kv <= i_din;
        end
    end

    assign o_kv = r_kv;

endmodule

// ===== design/lru_move_to_front_cache_top.sv =====
// Fully associative key/value cache of ENTRY_COUNT entries held in a row of cells in
// recency order, most recent at cell 0. A command is taken when start is high and busy
// is low; its result appears two cycles later as a one-cycle o_strobe pulse with no
// back-pressure, so the receiver must take it then. One command every 2 cycles: one
// cycle to register the command, one cycle in which every cell compares its key, the
// first match ripples down the row and the cells shift toward the back in place.
// Lookups return the value on a hit (entry moved to the front) or all ones on a miss;
// inserts place the pair at the front without checking for duplicates and drop the
// last entry when the capacity register's limit is reached. Write the capacity only
// while busy is low and no result is pending.
module lru_move_to_front_cache_top
    import lrumtf_pkg::*;
#(
    parameter int ENTRY_COUNT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item_in         i_item,
    output logic             o_strobe,
    output t_item_out        o_result,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    localparam int OW = $clog2(ENTRY_COUNT + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    t_state            r_state, n_state;
    t_item_in          r_in;
    logic [CAP_W-1:0]  r_cap;
    logic [OW-1:0]     r_occ;
    logic [DATA_W-1:0] r_hits, r_misses;
    logic              r_strobe;
    t_item_out         r_result;

    t_chain            w_chain [0:ENTRY_COUNT];
    t_kv               w_kv    [0:ENTRY_COUNT-1];
    logic [ENTRY_COUNT-1:0] w_load;
    t_kv               w_front;
    logic              w_exec;
    logic              w_hit;
    logic [OW-1:0]     w_cap, w_cap_new, w_last;

    function automatic logic [OW-1:0] f_eff_cap(input logic [CAP_W-1:0] c);
        logic [CW-1:0] cx;
        logic [CW-1:0] res;
        cx = CW'(c);
        if (c == '0) begin
            res = CW'(1);
        end else if (cx > CW'(ENTRY_COUNT)) begin
            res = CW'(ENTRY_COUNT);
        end else begin
            res = cx;
        end
        return OW'(res);
    endfunction

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b1;
        w_exec = 1'b0;
        unique case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: w_exec = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // cell row
    assign w_chain[0] = '{matched: 1'b0, value: '0};

    genvar g;
    generate
        for (g = 0; g < ENTRY_COUNT; g++) begin : g_cell
            t_kv w_din;
            if (g == 0) begin : g_head
                assign w_din = w_front;
            end else begin : g_body
                assign w_din = w_kv[g-1];
            end
            lrumtf_cell u_cell (
                .i_clk   (i_clk),
                .i_valid (OW'(g) < r_occ),
                .i_key   (r_in.key),
                .i_chain (w_chain[g]),
                .o_chain (w_chain[g+1]),
                .i_load  (w_load[g]),
                .i_din   (w_din),
                .o_kv    (w_kv[g])
            );
        end
    endgenerate

    assign w_hit     = w_chain[ENTRY_COUNT].matched;
    assign w_cap     = f_eff_cap(r_cap);
    assign w_cap_new = f_eff_cap(i_cfg_wdata);
    assign w_last    = (r_occ >= w_cap) ? (w_cap - OW'(1)) : r_occ;

    always_comb begin
        w_front.key   = r_in.key;
        w_front.value = (r_in.command == CMD_INSERT) ? r_in.value
                                                     : w_chain[ENTRY_COUNT].value;
    end

    always_comb begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (!w_exec) begin
                w_load[i] = 1'b0;
            end else if (r_in.command == CMD_INSERT) begin
                w_load[i] = (OW'(i) <= w_last);
            end else begin
                // entries in front of the first match slide back by one
                w_load[i] = w_hit && !w_chain[i].matched;
            end
        end
    end

    // occupancy, capacity, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_occ    <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
            if (r_occ > w_cap_new) begin
                r_occ <= w_cap_new;
            end
        end else if (w_exec) begin
            if (r_in.command == CMD_INSERT) begin
                r_occ <= (r_occ >= w_cap) ? w_cap : (r_occ + OW'(1));
            end else if (w_hit) begin
                r_hits <= r_hits + DATA_W'(1);
            end else begin
                r_misses <= r_misses + DATA_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            if (r_in.command == CMD_INSERT) begin
                r_result.hit         <= 1'b0;
                r_result.found_value <= '0;
                r_result.hit_total   <= r_hits;
                r_result.miss_total  <= r_misses;
            end else if (w_hit) begin
                r_result.hit         <= 1'b1;
                r_result.found_value <= w_chain[ENTRY_COUNT].value;
                r_result.hit_total   <= r_hits + DATA_W'(1);
                r_result.miss_total  <= r_misses;
            end else begin
                r_result.hit         <= 1'b0;
                r_result.found_value <= '1;
                r_result.hit_total   <= r_hits;
                r_result.miss_total  <= r_misses + DATA_W'(1);
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== design/lrumtf_checker.sv =====
module lrumtf_checker
    import lrumtf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_item_out o_result
);

    a_result_two_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_strobe)
        else $error("no result two cycles after accept");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_strobe)
        else $error("busy not raised after accept");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_nohit_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.hit |->
            (o_result.found_value == '1) || (o_result.found_value == '0))
        else $error("bad value on miss or insert");

endmodule

bind lru_move_to_front_cache_top lrumtf_checker u_lrumtf_checker (.*);

// ===== verif/tb.sv =====
module tb;
    import lrumtf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int QUIET_MAX  = 200;
    localparam int DRAIN_WAIT = 6;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item_in         i_item;
    logic             o_strobe;
    t_item_out        o_result;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    // mirror of the cache contents, most recent at slot 0
    logic [DATA_W-1:0] mirror_keys [SLOTS];
    logic [DATA_W-1:0] mirror_vals [SLOTS];
    int                mirror_fill;
    logic [DATA_W-1:0] mirror_hits;
    logic [DATA_W-1:0] mirror_misses;
    logic [CAP_W-1:0]  mirror_cap;

    t_item_out pending_results[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;

    lru_move_to_front_cache_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int usable_slots();
        int lim;
        lim = int'(mirror_cap);
        if (lim < 1) begin
            lim = 1;
        end
        if (lim > SLOTS) begin
            lim = SLOTS;
        end
        return lim;
    endfunction

    function automatic t_item_out cache_apply_command(t_item_in it);
        t_item_out         res;
        int                slot;
        int                hit_slot;
        int                last;
        logic [DATA_W-1:0] hold_val;
        res = '0;
        if (it.command == CMD_LOOKUP) begin
            hit_slot = -1;
            for (slot = 0; slot < mirror_fill; slot++) begin
                if (hit_slot < 0 && mirror_keys[slot] == it.key) begin
                    hit_slot = slot;
                end
            end
            if (hit_slot >= 0) begin
                hold_val = mirror_vals[hit_slot];
                for (slot = hit_slot; slot > 0; slot--) begin
                    mirror_keys[slot] = mirror_keys[slot-1];
                    mirror_vals[slot] = mirror_vals[slot-1];
                end
                mirror_keys[0]  = it.key;
                mirror_vals[0]  = hold_val;
                res.hit         = 1'b1;
                res.found_value = hold_val;
                mirror_hits     = mirror_hits + 1'b1;
            end else begin
                res.found_value = '1;
                mirror_misses   = mirror_misses + 1'b1;
            end
        end else begin
            if (mirror_fill >= usable_slots()) begin
                mirror_fill = usable_slots();
                last = mirror_fill - 1;
            end else begin
                last = mirror_fill;
                mirror_fill++;
            end
            for (slot = last; slot > 0; slot--) begin
                mirror_keys[slot] = mirror_keys[slot-1];
                mirror_vals[slot] = mirror_vals[slot-1];
            end
            mirror_keys[0] = it.key;
            mirror_vals[0] = it.value;
        end
        res.hit_total  = mirror_hits;
        res.miss_total = mirror_misses;
        return res;
    endfunction

    // drive one item and hold it until the block takes it
    task automatic send_item(input logic cmd, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] value);
        t_item_in it;
        logic     taken;
        it.command = cmd;
        it.key     = key;
        it.value   = value;
        start  <= 1'b1;
        i_item <= it;
        taken = 1'b0;
        while (taken !== 1'b1) begin
            @(negedge i_clk);
            taken = !busy;
            if (taken === 1'b1) begin
                pending_results.push_back(cache_apply_command(it));
            end
            @(posedge i_clk);
        end
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    // capacity is only written with the block drained and quiet
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror_cap = cap;
        if (mirror_fill > usable_slots()) begin
            mirror_fill = usable_slots();
        end
    endtask

    always @(negedge i_clk) begin
        t_item_out want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: hit %0b found %h", o_result.hit,
                             o_result.found_value);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_result.hit !== want.hit || o_result.found_value !== want.found_value ||
                    o_result.hit_total !== want.hit_total ||
                    o_result.miss_total !== want.miss_total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp/act: hit %0b/%0b found %h/%h", want.hit,
                                 o_result.hit, want.found_value, o_result.found_value);
                        $display("  hit_total %0d/%0d miss_total %0d/%0d", want.hit_total,
                                 o_result.hit_total, want.miss_total, o_result.miss_total);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no item taken, no result and no register write
    always @(negedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1 || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic test_lookup_empty();
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_LOOKUP, '1, '1);
    endtask

    task automatic test_insert_and_hit();
        send_item(CMD_INSERT, '0, '1);
        send_item(CMD_INSERT, '1, '0);
        send_item(CMD_LOOKUP, '1, 64'h1234);
        idle_burst();
        send_item(CMD_LOOKUP, '0, '0);
        // duplicate key: newest copy sits in front and wins
        send_item(CMD_INSERT, '0, 64'd5);
        send_item(CMD_LOOKUP, '0, '1);
        send_item(CMD_LOOKUP, 64'h5555_5555_5555_5555, '0);
    endtask

    task automatic test_capacity_zero_and_max();
        // zero behaves as one entry; shrinking drops the older entries
        set_capacity(5'd0);
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_LOOKUP, '1, '0);
        send_item(CMD_INSERT, 64'hA5A5_0000_FFFF_5A5A, 64'hDEAD_BEEF_0000_0001);
        send_item(CMD_LOOKUP, '0, '0);
        idle_burst();
        send_item(CMD_LOOKUP, 64'hA5A5_0000_FFFF_5A5A, '0);
        // above the slot count saturates to the full cache
        set_capacity(5'd31);
        send_item(CMD_INSERT, 64'h0000_0000_0000_00B0, 64'h8000_0000_0000_0000);
        send_item(CMD_INSERT, 64'h8000_0000_0000_00C0, 64'h0000_0000_0000_0001);
        send_item(CMD_LOOKUP, 64'hA5A5_0000_FFFF_5A5A, '0);
    endtask

    task automatic test_shrink_and_evict();
        set_capacity(5'd2);
        send_item(CMD_LOOKUP, 64'h0000_0000_0000_00B0, '0);
        send_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0F0F_0F0F_0F0F_0F0F);
        send_item(CMD_LOOKUP, 64'h8000_0000_0000_00C0, '0);
        send_item(CMD_LOOKUP, 64'hA5A5_0000_FFFF_5A5A, '0);
        set_capacity(CAP_RESET);
    endtask

    task automatic test_random_traffic();
        logic [DATA_W-1:0] pool [24];
        int                pool_len;
        int                phase;
        int                n;
        int                pick;
        bit                idle_on;
        logic [CAP_W-1:0]  cap;
        logic              cmd;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        for (phase = 0; phase < 8; phase++) begin
            unique case (phase)
                0: cap = 5'd1;
                1: cap = CAP_RESET;
                2: cap = 5'd0;
                3: cap = 5'd31;
                4: cap = 5'd17;
                7: cap = CAP_RESET;
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            set_capacity(cap);
            pool_len = $urandom_range(2, 24);
            for (n = 0; n < 24; n++) begin
                pool[n] = rand64();
            end
            idle_on = (phase != 2 && phase != 7);
            for (n = 0; n < 195; n++) begin
                cmd = ($urandom_range(0, 9) < 4) ? CMD_INSERT : CMD_LOOKUP;
                key = ($urandom_range(0, 9) == 0) ? rand64()
                                                  : pool[$urandom_range(0, pool_len - 1)];
                pick = $urandom_range(0, 7);
                if (pick == 0) begin
                    value = '0;
                end else if (pick == 1) begin
                    value = '1;
                end else begin
                    value = rand64();
                end
                send_item(cmd, key, value);
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    idle_burst();
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        mirror_fill   = 0;
        mirror_hits   = '0;
        mirror_misses = '0;
        mirror_cap    = CAP_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lookup_empty();
        test_insert_and_hit();
        test_capacity_zero_and_max();
        test_shrink_and_evict();
        test_random_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lrumtf_pkg.sv
design/lrumtf_cell.sv
design/lru_move_to_front_cache_top.sv
design/lrumtf_checker.sv
verif/tb.sv
